// ===== hw/rtl/tfdc_pkg.sv =====
// tfdc_pkg: constants, status and register codes and crc-32c helpers
// for the frame deframer and checker; no dependencies
`default_nettype none

package tfdc_pkg;

	localparam int unsigned JOINTS        = 7;
	localparam int unsigned HEADER_BYTES  = 40;
	localparam int unsigned PAYLOAD_BYTES = JOINTS * 4;
	localparam int unsigned CRC_OFFSET    = HEADER_BYTES + PAYLOAD_BYTES;
	localparam int unsigned FRAME_BYTES   = CRC_OFFSET + 4;

	localparam int unsigned CNT_W  = 9;
	localparam int unsigned JSEL_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

	localparam int unsigned MAGIC_BYTES    = 4;
	localparam int unsigned VERSION_OFFSET = 4;
	localparam int unsigned TYPE_OFFSET    = 5;
	localparam int unsigned FLAGS_OFFSET   = 6;
	localparam int unsigned SESSION_OFFSET = 8;
	localparam int unsigned PSIZE_OFFSET   = 12;
	localparam int unsigned JCOUNT_OFFSET  = 14;
	localparam int unsigned SEQ_OFFSET     = 16;
	localparam int unsigned TIME_OFFSET    = 24;
	localparam int unsigned LEASE_OFFSET   = 32;
	localparam int unsigned LEASE_END      = 36;

	localparam logic [7:0] PSIZE_LO  = 8'(PAYLOAD_BYTES);
	localparam logic [7:0] PSIZE_HI  = 8'(PAYLOAD_BYTES >> 8);
	localparam logic [7:0] JCOUNT_LO = 8'(JOINTS);
	localparam logic [7:0] JCOUNT_HI = 8'(JOINTS >> 8);

	localparam logic [31:0] CRC_POLY = 32'h82f6_3b78;
	localparam logic [31:0] CRC_INIT = 32'hffff_ffff;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_VERSION = 3'd1;
	localparam logic [2:0] ST_BAD_SHAPE   = 3'd2;
	localparam logic [2:0] ST_CRC         = 3'd3;
	localparam logic [2:0] ST_ZERO_FIELD  = 3'd4;
	localparam logic [2:0] ST_NONFINITE   = 3'd5;

	localparam logic [1:0] REG_MAGIC   = 2'd0;
	localparam logic [1:0] REG_VERSION = 2'd1;
	localparam logic [1:0] REG_TYPE    = 2'd2;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
		end
		return r;
	endfunction

	function automatic logic [31:0] crc_word(input logic [31:0] w);
		logic [31:0] r;
		r = CRC_INIT;
		for (int i = 0; i < 4; i++) begin
			r = crc_byte(r, w[8*i +: 8]);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/target_frame_deframer_checker.sv =====
// target_frame_deframer_checker: magic hunt, header checks, crc-32c and
// per-joint result burst for joint-target frames; uses tfdc_pkg
// one byte per cycle unless stalled; a result appears in the cycle after the
// transfer of the byte that ends a frame or a bad header, a good frame then
// gives one joint result per unstalled cycle; byte input stalls only while
// a result burst is pending and the frame in progress reaches its header end;
// async active-low reset skips position and result data; no clearing pass
`default_nettype none

module target_frame_deframer_checker
	import tfdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,

	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,

	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  status,
	output logic [31:0] session_word,
	output logic [63:0] sequence_number,
	output logic [63:0] sender_stamp,
	output logic [31:0] lease_period,
	output logic [3:0]  joint_index,
	output logic [31:0] position_bits,
	output logic        last
);

	localparam logic [CNT_W-1:0] C_MAGIC   = CNT_W'(MAGIC_BYTES);
	localparam logic [CNT_W-1:0] C_VER     = CNT_W'(VERSION_OFFSET);
	localparam logic [CNT_W-1:0] C_TYPE    = CNT_W'(TYPE_OFFSET);
	localparam logic [CNT_W-1:0] C_FLAGS   = CNT_W'(FLAGS_OFFSET);
	localparam logic [CNT_W-1:0] C_SESSION = CNT_W'(SESSION_OFFSET);
	localparam logic [CNT_W-1:0] C_PSIZE   = CNT_W'(PSIZE_OFFSET);
	localparam logic [CNT_W-1:0] C_JCOUNT  = CNT_W'(JCOUNT_OFFSET);
	localparam logic [CNT_W-1:0] C_SEQ     = CNT_W'(SEQ_OFFSET);
	localparam logic [CNT_W-1:0] C_TIME    = CNT_W'(TIME_OFFSET);
	localparam logic [CNT_W-1:0] C_LEASE   = CNT_W'(LEASE_OFFSET);
	localparam logic [CNT_W-1:0] C_LEND    = CNT_W'(LEASE_END);
	localparam logic [CNT_W-1:0] C_HDR     = CNT_W'(HEADER_BYTES);
	localparam logic [CNT_W-1:0] C_CRC     = CNT_W'(CRC_OFFSET);
	localparam logic [CNT_W-1:0] C_FRAME   = CNT_W'(FRAME_BYTES);
	localparam logic [3:0]       J_LAST    = 4'(JOINTS - 1);
	localparam logic [6:0]       J_NUM     = 7'(JOINTS);

	// configuration
	logic [31:0] magic_q;
	logic [7:0]  version_q;
	logic [7:0]  ftype_q;

	// deframer state
	logic [31:0]      window_q;
	logic             in_frame_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      crc_q;
	logic [31:0]      rx_crc_q;
	logic             ver_ok_q;
	logic             shape_ok_q;
	logic [31:0]      session_q;
	logic [63:0]      seq_q;
	logic [63:0]      time_q;
	logic [31:0]      lease_q;
	logic [31:0]      pos_q [JOINTS];
	logic             nonfin_q;

	// result register
	logic        res_valid_q;
	logic [2:0]  res_status_q;
	logic [31:0] res_session_q;
	logic [63:0] res_seq_q;
	logic [63:0] res_time_q;
	logic [31:0] res_lease_q;
	logic [3:0]  jnt_q;

	logic             cfg_wr;
	logic             byte_xfer;
	logic             res_xfer;
	logic [7:0]       b;
	logic [31:0]      win_nx;
	logic [CNT_W-1:0] hunt_cnt;
	logic             match;
	logic [CNT_W-1:0] cnt_inc;
	logic [CNT_W-1:0] off;
	logic [CNT_W-1:0] crc_off;
	logic [6:0]       jfull;
	logic [JSEL_W-1:0] jw;
	logic             in_payload;
	logic             in_crc;
	logic [31:0]      rx_full;
	logic             hdr_end;
	logic             frm_end;
	logic [2:0]       emit_status;
	logic             emit;

	assign cfg_wr    = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign byte_xfer = byte_valid && !byte_stall;
	assign res_xfer  = res_valid_q && !result_stall;
	assign b         = data_byte;

	always_comb begin
		case (paddr[3:2])
			REG_MAGIC:   prdata = magic_q;
			REG_VERSION: prdata = {24'd0, version_q};
			REG_TYPE:    prdata = {24'd0, ftype_q};
			default:     prdata = 32'd0;
		endcase
	end

	// hunting
	assign win_nx   = {b, window_q[31:8]};
	assign hunt_cnt = (count_q < C_MAGIC) ? count_q + 1'b1 : count_q;
	assign match    = (hunt_cnt >= C_MAGIC) && (win_nx == magic_q);

	// in frame
	assign cnt_inc    = count_q + 1'b1;
	assign off        = count_q - C_HDR;
	assign crc_off    = count_q - C_CRC;
	assign jfull      = off[8:2];
	assign jw         = jfull[JSEL_W-1:0];
	assign in_payload = (count_q >= C_HDR) && (count_q < C_CRC) && (jfull < J_NUM);
	assign in_crc     = (count_q >= C_CRC) && (count_q < C_FRAME);

	always_comb begin
		rx_full = rx_crc_q;
		if (in_crc) begin
			rx_full[8*crc_off[1:0] +: 8] = b;
		end
	end

	assign hdr_end = in_frame_q && (cnt_inc == C_HDR) && !(ver_ok_q && shape_ok_q);
	assign frm_end = in_frame_q && (cnt_inc >= C_FRAME);

	always_comb begin
		if (hdr_end) begin
			emit_status = ver_ok_q ? ST_BAD_SHAPE : ST_BAD_VERSION;
		end else if (~crc_q != rx_full) begin
			emit_status = ST_CRC;
		end else if (session_q == '0 || seq_q == '0 || lease_q == '0) begin
			emit_status = ST_ZERO_FIELD;
		end else if (nonfin_q) begin
			emit_status = ST_NONFINITE;
		end else begin
			emit_status = ST_OK;
		end
	end

	assign emit = byte_xfer && (hdr_end || frm_end);

	// hold bytes while a burst is pending from the frame's last header byte on
	assign byte_stall = res_valid_q && in_frame_q && (count_q >= C_HDR - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= '0;
			version_q <= 8'd1;
			ftype_q   <= 8'd1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MAGIC:   magic_q   <= pwdata;
				REG_VERSION: version_q <= pwdata[7:0];
				REG_TYPE:    ftype_q   <= pwdata[7:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			in_frame_q <= 1'b0;
			count_q    <= '0;
			crc_q      <= CRC_INIT;
			rx_crc_q   <= '0;
			ver_ok_q   <= 1'b1;
			shape_ok_q <= 1'b1;
			session_q  <= '0;
			seq_q      <= '0;
			time_q     <= '0;
			lease_q    <= '0;
			nonfin_q   <= 1'b0;
		end else if (byte_xfer) begin
			if (!in_frame_q) begin
				window_q <= win_nx;
				if (match) begin
					crc_q      <= crc_word(win_nx);
					in_frame_q <= 1'b1;
					count_q    <= C_MAGIC;
					rx_crc_q   <= '0;
					ver_ok_q   <= 1'b1;
					shape_ok_q <= 1'b1;
					session_q  <= '0;
					seq_q      <= '0;
					time_q     <= '0;
					lease_q    <= '0;
					nonfin_q   <= 1'b0;
				end else begin
					count_q <= hunt_cnt;
				end
			end else begin
				if (count_q < C_CRC) begin
					crc_q <= crc_byte(crc_q, b);
				end
				if (count_q == C_VER) begin
					ver_ok_q <= (b == version_q);
				end else if (count_q == C_TYPE) begin
					shape_ok_q <= shape_ok_q && (b == ftype_q);
				end else if (count_q == C_FLAGS || count_q == C_FLAGS + 1'b1) begin
					shape_ok_q <= shape_ok_q && (b == 8'd0);
				end else if (count_q == C_PSIZE) begin
					shape_ok_q <= shape_ok_q && (b == PSIZE_LO);
				end else if (count_q == C_PSIZE + 1'b1) begin
					shape_ok_q <= shape_ok_q && (b == PSIZE_HI);
				end else if (count_q == C_JCOUNT) begin
					shape_ok_q <= shape_ok_q && (b == JCOUNT_LO);
				end else if (count_q == C_JCOUNT + 1'b1) begin
					shape_ok_q <= shape_ok_q && (b == JCOUNT_HI);
				end
				if (count_q >= C_SESSION && count_q < C_PSIZE) begin
					session_q[8*count_q[1:0] +: 8] <= b;
				end else if (count_q >= C_SEQ && count_q < C_TIME) begin
					seq_q[8*count_q[2:0] +: 8] <= b;
				end else if (count_q >= C_TIME && count_q < C_LEASE) begin
					time_q[8*count_q[2:0] +: 8] <= b;
				end else if (count_q >= C_LEASE && count_q < C_LEND) begin
					lease_q[8*count_q[1:0] +: 8] <= b;
				end
				// exponent all ones once the top byte of a position lands
				if (in_payload && off[1:0] == 2'd3 && {b[6:0], pos_q[jw][23]} == 8'hff) begin
					nonfin_q <= 1'b1;
				end
				rx_crc_q <= rx_full;
				if (hdr_end || frm_end) begin
					in_frame_q <= 1'b0;
					window_q   <= '0;
					count_q    <= '0;
				end else begin
					count_q <= cnt_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_xfer && in_frame_q && in_payload) begin
			pos_q[jw][8*off[1:0] +: 8] <= b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			jnt_q       <= '0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
			jnt_q       <= '0;
		end else if (res_xfer) begin
			if (last) begin
				res_valid_q <= 1'b0;
			end else begin
				jnt_q <= jnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_status_q <= emit_status;
			if (emit_status == ST_OK) begin
				res_session_q <= session_q;
				res_seq_q     <= seq_q;
				res_time_q    <= time_q;
				res_lease_q   <= lease_q;
			end else begin
				res_session_q <= '0;
				res_seq_q     <= '0;
				res_time_q    <= '0;
				res_lease_q   <= '0;
			end
		end
	end

	assign result_valid    = res_valid_q;
	assign status          = res_status_q;
	assign session_word    = res_session_q;
	assign sequence_number = res_seq_q;
	assign sender_stamp    = res_time_q;
	assign lease_period    = res_lease_q;
	assign joint_index     = (res_status_q == ST_OK) ? jnt_q : 4'd0;
	assign position_bits   = (res_status_q == ST_OK) ? pos_q[jnt_q[JSEL_W-1:0]] : 32'd0;
	assign last            = (res_status_q != ST_OK) || (jnt_q == J_LAST);

`ifndef SYNTH
	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> result_valid)
		else $error("result burst ended before its last joint");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_OK |-> last && position_bits == 32'd0 &&
		session_word == 32'd0 && joint_index == 4'd0)
		else $error("status result carries frame data");

	a_joint_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> jnt_q <= J_LAST)
		else $error("joint index beyond joint count");

	a_frame_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_frame_q |-> count_q >= C_MAGIC && count_q < C_FRAME)
		else $error("byte count out of frame range");

	a_hunt_count: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> count_q <= C_MAGIC)
		else $error("hunt count beyond magic length");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last && !result_stall |=> !$rose(result_valid) && result_valid)
		else $error("result burst lost mid-way");
`endif

endmodule

`default_nettype wire
